// ----- rtl/lkt_pkg.sv -----
// shared types and constants for the lfu keyed table
// no dependencies
package lkt_pkg;

  localparam int IDX_W   = 6;
  localparam int COUNT_W = 32;
  localparam int MAX_OUT = 16;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_REJECTED  = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  localparam logic [2:0] FUNC_PUT    = 3'd0;
  localparam logic [2:0] FUNC_GET    = 3'd1;
  localparam logic [2:0] FUNC_POP    = 3'd2;
  localparam logic [2:0] FUNC_RESIZE = 3'd3;
  localparam logic [2:0] FUNC_TOPK   = 3'd4;

  typedef enum logic [1:0] {
    SCAN_KEY,
    SCAN_VICTIM,
    SCAN_FREE,
    SCAN_RANK
  } scan_mode_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SET_VALUE,
    CMD_BUMP,
    CMD_REMOVE,
    CMD_INSERT,
    CMD_CLEAR,
    CMD_UNTAKE,
    CMD_TAKE
  } cmd_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_CHECK,
    S_VICTIM,
    S_FREE,
    S_RANK
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] lookup_key;
    logic [31:0] new_value;
    logic [15:0] amount;
  } lkt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_key;
    logic [31:0] out_value;
    logic [6:0]  out_count;
    logic        last;
  } lkt_out_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   age;
    logic [COUNT_W-1:0] count;
    logic [31:0]        key;
    logic [31:0]        value;
  } lkt_cand_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] age;
    logic [31:0]      key;
    logic [31:0]      value;
  } lkt_cmd_t;

endpackage

// ----- rtl/lfu_keyed_table.sv -----
// top level of the lfu keyed table: sequencer and the chain of entry cells
// depends on lkt_pkg and lkt_cell
//
// usage: present an item on in_item and raise start; it is taken at an edge
// where start is high and busy is low. busy stays high until the item is done.
// results appear on out_item for one cycle each, marked by out_strobe; the
// receiver cannot stall, every result beat is taken when shown.
// every operation gives one result beat, except top k which gives up to
// min(k, 16, entries held) beats, the last one with last set.
// each search runs a candidate down the row of ENTRIES cells, one cell per
// cycle, registered in each cell; its cell command is applied at the edge that
// ends the search, and any result beat is registered at that same edge.
// get, a put hit: one lookup search, then the beat. put miss: lookup search,
// then a check step and a search per eviction, then a check step and a
// free-slot search. pop and resize: a check step and a search per evicted
// entry, then a closing check step.
// top k: one search per emitted beat. undefined codes, resize to zero and an
// empty top k: one beat in the cycle after the accepting edge, busy stays low.
// reset empties the table and sets the capacity to ENTRIES; no clearing pass.
module lfu_keyed_table
  import lkt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lkt_in_t  in_item,
  output logic     out_strobe,
  output lkt_out_t out_item
);

  localparam int CW = $clog2(ENTRIES + 1);

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  lkt_in_t     in_r, in_nxt;
  logic [6:0]  held_r, held_nxt, cap_r, cap_nxt, new_cap_r, new_cap_nxt;
  logic [6:0]  lim_r, lim_nxt, cap_in, lim_a, lim_b, lim_in;
  logic [15:0] rem_r, rem_nxt;
  logic [4:0]  rank_r, rank_nxt;
  logic        strobe_nxt, done, rank_last;
  lkt_out_t    out_r, out_nxt;
  lkt_cmd_t    cmd;
  scan_mode_t  mode;
  lkt_cand_t   chain [ENTRIES];
  lkt_cand_t   res;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      lkt_cell #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS), .IDX(g)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .scan_key (in_r.lookup_key),
        .cand_in  ((g == 0) ? lkt_cand_t'('0) : chain[(g == 0) ? 0 : g-1]),
        .cand_out (chain[g]),
        .cmd      (cmd)
      );
    end
  endgenerate

  assign res  = chain[ENTRIES-1];
  assign busy = (state_r != S_IDLE);
  assign done = (cnt_r == CW'(ENTRIES));
  assign rank_last = ((7'(rank_r) + 7'd1) == lim_r);

  assign cap_in = (in_item.amount > 16'(ENTRIES)) ? 7'(ENTRIES) : in_item.amount[6:0];
  assign lim_a  = (7'(MAX_OUT) < cap_in) ? 7'(MAX_OUT) : cap_in;
  assign lim_b  = (held_r < lim_a) ? held_r : lim_a;
  assign lim_in = lim_b;

  always_comb begin
    case (state_r)
      S_VICTIM: mode = SCAN_VICTIM;
      S_FREE:   mode = SCAN_FREE;
      S_RANK:   mode = SCAN_RANK;
      default:  mode = SCAN_KEY;
    endcase
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    in_nxt      = in_r;
    held_nxt    = held_r;
    cap_nxt     = cap_r;
    new_cap_nxt = new_cap_r;
    lim_nxt     = lim_r;
    rem_nxt     = rem_r;
    rank_nxt    = rank_r;
    cnt_nxt     = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt = in_item;
          case (in_item.func)
            FUNC_PUT, FUNC_GET: state_nxt = S_FIND;
            FUNC_POP: begin
              rem_nxt   = in_item.amount;
              state_nxt = S_CHECK;
            end
            FUNC_RESIZE: begin
              new_cap_nxt = cap_in;
              if (cap_in == 7'd0) begin
                held_nxt = '0;
                cap_nxt  = '0;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            FUNC_TOPK: begin
              lim_nxt  = lim_in;
              rank_nxt = '0;
              if (lim_in != 7'd0) state_nxt = S_RANK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        case (in_r.func)
          FUNC_PUT: state_nxt = (held_r >= cap_r) ? S_VICTIM : S_FREE;
          FUNC_POP: begin
            state_nxt = (rem_r != '0 && held_r != '0) ? S_VICTIM : S_IDLE;
          end
          default: begin
            if (held_r > new_cap_r) begin
              state_nxt = S_VICTIM;
            end else begin
              cap_nxt   = new_cap_r;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_FIND: begin
        if (!done) cnt_nxt = cnt_r + 1'b1;
        else if (in_r.func == FUNC_PUT && !res.found && cap_r != '0) state_nxt = S_CHECK;
        else state_nxt = S_IDLE;
      end
      S_VICTIM: begin
        if (!done) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (res.found) begin
            held_nxt = held_r - 1'b1;
            if (rem_r != '0) rem_nxt = rem_r - 1'b1;
          end
          state_nxt = S_CHECK;
        end
      end
      S_FREE: begin
        if (!done) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          if (res.found) held_nxt = held_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RANK: begin
        if (!done) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          rank_nxt = rank_r + 1'b1;
          if (rank_last || !res.found) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // cell commands and result beats
  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_NONE;
    cmd.idx    = res.idx;
    cmd.age    = res.age;
    cmd.key    = in_r.lookup_key;
    cmd.value  = in_r.new_value;
    strobe_nxt = 1'b0;
    out_nxt    = '0;
    out_nxt.out_count = held_nxt;
    out_nxt.last      = 1'b1;
    out_nxt.status    = STATUS_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_item.func)
            FUNC_PUT, FUNC_GET, FUNC_POP: ;
            FUNC_RESIZE: begin
              if (cap_in == 7'd0) begin
                cmd.kind   = CMD_CLEAR;
                strobe_nxt = 1'b1;
              end
            end
            FUNC_TOPK: begin
              cmd.kind = CMD_UNTAKE;
              if (lim_in == 7'd0) begin
                strobe_nxt     = 1'b1;
                out_nxt.status = STATUS_EMPTY;
              end
            end
            default: strobe_nxt = 1'b1;
          endcase
        end
      end
      S_CHECK: begin
        if (state_nxt == S_IDLE) strobe_nxt = 1'b1;
      end
      S_FIND: begin
        if (done) begin
          if (in_r.func == FUNC_PUT) begin
            if (res.found) begin
              cmd.kind   = CMD_SET_VALUE;
              strobe_nxt = 1'b1;
            end else if (cap_r == '0) begin
              strobe_nxt     = 1'b1;
              out_nxt.status = STATUS_REJECTED;
            end
          end else begin
            strobe_nxt = 1'b1;
            if (res.found) begin
              cmd.kind          = CMD_BUMP;
              out_nxt.out_value = res.value;
            end else begin
              out_nxt.status = STATUS_NOT_FOUND;
            end
          end
        end
      end
      S_VICTIM: begin
        if (done && res.found) cmd.kind = CMD_REMOVE;
      end
      S_FREE: begin
        if (done) begin
          strobe_nxt = 1'b1;
          if (res.found) cmd.kind = CMD_INSERT;
          else out_nxt.status = STATUS_REJECTED;
        end
      end
      S_RANK: begin
        if (done) begin
          strobe_nxt = 1'b1;
          if (res.found) begin
            cmd.kind          = CMD_TAKE;
            out_nxt.out_key   = res.key;
            out_nxt.out_value = res.value;
            out_nxt.last      = rank_last;
          end else begin
            out_nxt.status = (rank_r == '0) ? STATUS_EMPTY : STATUS_OK;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      held_r     <= '0;
      cap_r      <= 7'(ENTRIES);
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      held_r     <= held_nxt;
      cap_r      <= cap_nxt;
      out_strobe <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    new_cap_r <= new_cap_nxt;
    lim_r     <= lim_nxt;
    rem_r     <= rem_nxt;
    rank_r    <= rank_nxt;
    out_r     <= out_nxt;
  end

  assign out_item = out_r;

endmodule

// ----- rtl/lkt_cell.sv -----
// one table entry with its stage of the search chain
// depends on lkt_pkg
module lkt_cell
  import lkt_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16,
  parameter int IDX        = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  scan_mode_t  mode,
  input  logic [31:0] scan_key,
  input  lkt_cand_t   cand_in,
  output lkt_cand_t   cand_out,
  input  lkt_cmd_t    cmd
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic                  valid_r, taken_r;
  logic [31:0]           key_r, value_r;
  logic [COUNT_BITS-1:0] count_r, count_inc;
  logic [AW-1:0]         age_r;
  lkt_cand_t             mine, cand_r, cand_nxt;
  logic                  better, hit;

  assign hit       = (cmd.idx == IDX_W'(IDX));
  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  always_comb begin
    mine.found = 1'b1;
    mine.idx   = IDX_W'(IDX);
    mine.age   = IDX_W'(age_r);
    mine.count = COUNT_W'(count_r);
    mine.key   = key_r;
    mine.value = value_r;
  end

  always_comb begin
    better = 1'b0;
    case (mode)
      SCAN_KEY: better = valid_r && !cand_in.found && key_r == scan_key;
      SCAN_FREE: better = !valid_r && !cand_in.found;
      SCAN_VICTIM: begin
        better = valid_r && (!cand_in.found || mine.count < cand_in.count ||
                 (mine.count == cand_in.count && mine.age < cand_in.age));
      end
      SCAN_RANK: begin
        better = valid_r && !taken_r && (!cand_in.found ||
                 mine.count > cand_in.count ||
                 (mine.count == cand_in.count && (value_r < cand_in.value ||
                 (value_r == cand_in.value && mine.age < cand_in.age))));
      end
      default: better = 1'b0;
    endcase
    cand_nxt = better ? mine : cand_in;
  end

  assign cand_out = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      taken_r <= 1'b0;
      cand_r  <= '0;
    end else begin
      cand_r <= cand_nxt;
      case (cmd.kind)
        CMD_SET_VALUE: begin
          if (hit) begin
            value_r <= cmd.value;
            count_r <= count_inc;
          end
        end
        CMD_BUMP: begin
          if (hit) count_r <= count_inc;
        end
        CMD_REMOVE: begin
          if (hit) valid_r <= 1'b0;
          else if (valid_r && IDX_W'(age_r) > cmd.age) age_r <= age_r - 1'b1;
        end
        CMD_INSERT: begin
          if (hit) begin
            valid_r <= 1'b1;
            key_r   <= cmd.key;
            value_r <= cmd.value;
            count_r <= '0;
            age_r   <= '0;
          end else if (valid_r) begin
            age_r <= age_r + 1'b1;
          end
        end
        CMD_CLEAR:  valid_r <= 1'b0;
        CMD_UNTAKE: taken_r <= 1'b0;
        CMD_TAKE: begin
          if (hit) taken_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
